[design/sbi_pkg.sv]
// shared command codes for the breakpoint interpolator
`timescale 1ns / 1ps
package sbi_pkg;
    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_MOVE   = 3'd2;
    localparam logic [2:0] CMD_EVAL   = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;
endpackage

[design/sbi_div.sv]
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module sbi_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [33:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quo
);
    import sbi_pkg::*;
    logic [33:0] r_num;
    logic [16:0] r_rem;
    logic [15:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [17:0] w_trial;
    logic [16:0] w_sh;
    assign w_sh    = {r_rem[15:0], r_num[33]};
    assign w_trial = {1'b0, w_sh} - {2'b00, r_den};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == 6'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= 6'd34;
            end else if (r_busy) begin
                r_num <= {r_num[32:0], ~w_trial[17]};
                r_rem <= w_trial[17] ? w_sh : w_trial[16:0];
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end
    assign o_done = r_done;
    // quotient always fits 16 bits since it lies between the two y values
    assign o_quo = r_num[15:0];
endmodule

[design/sorted_breakpoint_interpolator_top.sv]
// top level: command sequencer around the breakpoint memory
`timescale 1ns / 1ps
// Breakpoint table of up to MAX_POINTS (x,y) Q0.16 points kept sorted by x in one
// synchronous memory with a registered read. One command is handled at a time.
// Clear, unknown commands and faults go straight to the output state; insert scans
// for its slot and shifts the table up, remove shifts it down, each moved entry read
// and then written; a move does a remove and then an insert. Evaluate reads the
// first and last points, walks until the segment is found and runs a bit-serial
// divider over a 34-bit numerator. The result waits in an output register until
// taken, and the next command may start meanwhile.
module sorted_breakpoint_interpolator_top #(
    parameter int MAX_POINTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // command[2:0], index[7:3], pos_x[23:8], pos_y[39:24]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // slot[5:0], value[21:6], point_total[27:22], fault[28]
);
    import sbi_pkg::*;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int IW = (CW > 5) ? CW : 5;
    localparam logic [3:0] S_IDLE = 4'd0, S_FIND = 4'd1, S_SHUP = 4'd2, S_SHDN = 4'd3,
                           S_EVAL = 4'd4, S_DIV = 4'd5, S_OUT = 4'd6, S_WAIT = 4'd7,
                           S_ELST = 4'd8;

    logic [31:0]   r_mem [MAX_POINTS];
    logic [31:0]   r_rd;
    logic [AW-1:0] r_raddr, n_raddr;
    logic          r_we, n_we;
    logic [AW-1:0] r_waddr, n_waddr;
    logic [31:0]   r_wdata, n_wdata;
    always_ff @(posedge i_clk) begin
        if (r_we) r_mem[r_waddr] <= r_wdata;
        r_rd <= r_mem[r_raddr];
    end

    logic [3:0]    r_st, n_st;
    logic [2:0]    r_cmd, n_cmd;
    logic [15:0]   r_px, n_px, r_py, n_py;
    logic [CW-1:0] r_cnt, n_cnt, r_i, n_i, r_slot, n_slot;
    logic [31:0]   r_prev, n_prev;
    logic          r_first, n_first, r_rv, n_rv;
    logic          r_fault, n_fault;
    logic [15:0]   r_val, n_val;
    logic [5:0]    r_oslot, n_oslot, r_otot, n_otot;
    logic          r_ofault, n_ofault;
    logic [15:0]   r_oval, n_oval;
    logic          r_ov, n_ov;
    logic          r_dstart, n_dstart;
    logic [33:0]   r_dnum, n_dnum;
    logic [15:0]   r_dden, n_dden;
    logic          w_ddone;
    logic [15:0]   w_dq;
    logic [IW-1:0] w_idx;
    logic [15:0]   w_dx1, w_dx0;
    logic [31:0]   w_m0, w_m1;
    assign w_idx = IW'(s_axis_tdata[7:3]);
    assign w_dx1 = r_rd[15:0] - r_px;
    assign w_dx0 = r_px - r_prev[15:0];
    assign w_m0  = r_prev[31:16] * w_dx1;
    assign w_m1  = r_rd[31:16] * w_dx0;

    sbi_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart), .i_num(r_dnum),
                   .i_den(r_dden), .o_done(w_ddone), .o_quo(w_dq));

    assign s_axis_tready = (r_st == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {3'b0, r_ofault, r_otot, r_oval, r_oslot};

    always_comb begin
        n_st = r_st; n_cmd = r_cmd; n_px = r_px; n_py = r_py; n_cnt = r_cnt;
        n_i = r_i; n_slot = r_slot; n_prev = r_prev; n_first = r_first; n_rv = r_rv;
        n_fault = r_fault; n_val = r_val; n_raddr = r_raddr; n_we = 1'b0;
        n_waddr = r_waddr; n_wdata = r_wdata; n_dstart = 1'b0; n_dnum = r_dnum;
        n_dden = r_dden; n_ov = r_ov && !m_axis_tready; n_oslot = r_oslot;
        n_oval = r_oval; n_otot = r_otot; n_ofault = r_ofault;
        unique case (r_st)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_cmd = s_axis_tdata[2:0]; n_px = s_axis_tdata[23:8];
                    n_py = s_axis_tdata[39:24];
                    n_fault = 1'b0; n_slot = '0; n_val = '0;
                    n_i = '0; n_raddr = '0; n_first = 1'b1; n_rv = 1'b0;
                    unique case (s_axis_tdata[2:0])
                        CMD_INSERT: begin
                            if (r_cnt >= CW'(MAX_POINTS)) begin
                                n_fault = 1'b1; n_st = S_OUT;
                            end else n_st = S_FIND;
                        end
                        CMD_REMOVE, CMD_MOVE: begin
                            if (w_idx >= IW'(r_cnt)) begin
                                n_fault = 1'b1; n_st = S_OUT;
                            end else begin
                                n_i = CW'(w_idx); n_raddr = AW'(w_idx + 1'b1);
                                n_st = S_SHDN;
                            end
                        end
                        CMD_EVAL: begin
                            if (r_cnt == '0) begin
                                n_val = 16'd32768; n_st = S_OUT;
                            end else n_st = S_EVAL;
                        end
                        CMD_CLEAR: begin n_cnt = '0; n_st = S_OUT; end
                        default: n_st = S_OUT;
                    endcase
                end
            end
            // scan for first x not below pos_x, one read per cycle
            S_FIND: begin
                if (r_rv && r_rd[15:0] >= r_px) begin
                    n_slot = r_i - 1'b1; n_i = r_cnt;
                    n_raddr = AW'(r_cnt - 1'b1); n_rv = 1'b0; n_st = S_SHUP;
                end else if (r_i == r_cnt) begin
                    n_slot = r_cnt; n_i = r_cnt;
                    n_raddr = AW'(r_cnt - 1'b1); n_rv = 1'b0; n_st = S_SHUP;
                end else begin
                    n_rv = 1'b1; n_i = r_i + 1'b1; n_raddr = AW'(r_i + 1'b1);
                end
            end
            // shift entries up from the end down to slot, then write the point
            S_SHUP: begin
                if (r_i == r_slot) begin
                    n_we = 1'b1; n_waddr = AW'(r_slot); n_wdata = {r_py, r_px};
                    n_cnt = r_cnt + 1'b1; n_st = S_WAIT;
                    if (r_cmd == CMD_MOVE) n_slot = '0;
                end else if (!r_rv) begin
                    n_rv = 1'b1;
                end else begin
                    n_we = 1'b1; n_waddr = AW'(r_i); n_wdata = r_rd;
                    n_i = r_i - 1'b1; n_raddr = AW'(r_i - 2'd2); n_rv = 1'b0;
                end
            end
            // close the gap left by a removed entry
            S_SHDN: begin
                if (r_i + 1'b1 >= r_cnt) begin
                    n_cnt = r_cnt - 1'b1; n_rv = 1'b0;
                    if (r_cmd == CMD_MOVE) begin
                        n_i = '0; n_raddr = '0; n_st = S_WAIT;
                        n_first = 1'b0;
                    end else n_st = S_OUT;
                end else if (!r_rv) begin
                    n_rv = 1'b1;
                end else begin
                    n_we = 1'b1; n_waddr = AW'(r_i); n_wdata = r_rd;
                    n_i = r_i + 1'b1; n_raddr = AW'(r_i + 2'd2); n_rv = 1'b0;
                end
            end
            // wait state so the last write lands before a move's scan, else go to output
            S_WAIT: begin
                n_i = '0; n_raddr = '0; n_rv = 1'b0;
                if (!r_first) begin n_first = 1'b1; n_st = S_FIND; end
                else n_st = S_OUT;
            end
            S_EVAL: begin
                if (!r_rv) begin
                    n_rv = 1'b1; n_i = r_i + 1'b1; n_raddr = AW'(r_i + 1'b1);
                end else if (r_first) begin
                    if (r_px <= r_rd[15:0] || r_cnt == CW'(1)) begin
                        n_val = r_rd[31:16]; n_st = S_OUT;
                    end else begin
                        // check the last point before walking the segments
                        n_prev = r_rd; n_first = 1'b0; n_rv = 1'b0;
                        n_raddr = AW'(r_cnt - 1'b1); n_st = S_ELST;
                    end
                end else if (r_px <= r_rd[15:0]) begin
                    n_dnum = 34'(w_m0) + 34'(w_m1);
                    n_dden = r_rd[15:0] - r_prev[15:0];
                    n_val = r_prev[31:16];
                    if (r_rd[15:0] == r_prev[15:0]) n_st = S_OUT;
                    else begin n_dstart = 1'b1; n_st = S_DIV; end
                end else if (r_i == r_cnt) begin
                    n_val = r_rd[31:16]; n_st = S_OUT;
                end else begin
                    n_prev = r_rd;
                    n_i = r_i + 1'b1; n_raddr = AW'(r_i + 1'b1);
                end
            end
            S_ELST: begin
                if (!r_rv) begin
                    n_rv = 1'b1;
                end else if (r_px >= r_rd[15:0]) begin
                    n_val = r_rd[31:16]; n_st = S_OUT;
                end else begin
                    n_rv = 1'b0; n_raddr = AW'(r_i); n_st = S_EVAL;
                end
            end
            S_DIV: begin
                if (w_ddone) begin n_val = w_dq; n_st = S_OUT; end
            end
            S_OUT: begin
                if (!r_ov || m_axis_tready) begin
                    n_ov = 1'b1; n_oslot = 6'(r_slot); n_oval = r_val;
                    n_otot = 6'(r_cnt); n_ofault = r_fault; n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_ov <= 1'b0; r_we <= 1'b0; r_dstart <= 1'b0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_ov <= n_ov; r_we <= n_we; r_dstart <= n_dstart;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_px <= n_px; r_py <= n_py; r_i <= n_i; r_slot <= n_slot;
        r_prev <= n_prev; r_first <= n_first; r_rv <= n_rv; r_fault <= n_fault;
        r_val <= n_val; r_raddr <= n_raddr; r_waddr <= n_waddr; r_wdata <= n_wdata;
        r_dnum <= n_dnum; r_dden <= n_dden; r_oslot <= n_oslot; r_oval <= n_oval;
        r_otot <= n_otot; r_ofault <= n_ofault;
    end
endmodule
